FILE: rtl/jdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_pkg: joystick dead-zone speed mapper shared definitions
// Sizing constants, reset values and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package jdsm_pkg;

   // block sizing
   localparam int CALIB_SAMPLES = 100;
   localparam int SAMPLE_BITS   = 10;

   localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;
   localparam int SPEED_MAX     = 100;
   localparam int SPEED_W       = 8;
   localparam int DZ_W          = 9;
   localparam int DZ_RESET      = 20;
   localparam int CENTRE_RST    = 512 % (1 << SAMPLE_BITS);

   // derived widths
   localparam int SUM_W     = $clog2(CALIB_SAMPLES * FULL_SCALE + 1);
   localparam int PROD_W    = $clog2(FULL_SCALE * SPEED_MAX + 1);
   localparam int NUM_W     = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int CNT_W     = $clog2(CALIB_SAMPLES + 1);
   localparam int DEN_W     = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam int DEV_W     = SAMPLE_BITS + 2;

   // register map
   localparam int ADDR_W = 3;
   localparam logic REG_DZ_THRESH = 1'b0;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the input word
      logic eval;      // classify axes / accumulate, launch dividers
      logic finish;    // load the result word, commit centres
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_needed;
      logic div_busy;
      logic calibrated;
   } dp_status_type;

   // per-axis classification held across the division
   typedef struct packed {
      logic zero;
      logic sat;
      logic pos;
   } axis_flags_type;

endpackage

FILE: rtl/jdsm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, NUM_W bits per divide.
// ----------------------------------------------------------------------------
module jdsm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [jdsm_pkg::NUM_W-1:0] num,
   input  logic [jdsm_pkg::DEN_W-1:0] den,
   output logic                       busy,
   output logic [jdsm_pkg::NUM_W-1:0] quotient
);
   import jdsm_pkg::*;

   logic [DEN_W:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]     rem_sh;
   logic [DEN_W:0]     diff;
   logic               fits;

   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff   = rem_sh - {1'b0, den_ff};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = DIV_CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? diff : rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

FILE: rtl/jdsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_datapath: calibration sums, centres, axis mapping and result register
// Two divider lanes, one per axis, shared by centre averaging and speed scaling.
// ----------------------------------------------------------------------------
module jdsm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  jdsm_pkg::dp_cmd_type            cmd,
   output jdsm_pkg::dp_status_type         status,
   input  logic [jdsm_pkg::DZ_W-1:0]       dz_thresh,
   input  logic                            in_op,
   input  logic [jdsm_pkg::SAMPLE_BITS-1:0] in_sample_x,
   input  logic [jdsm_pkg::SAMPLE_BITS-1:0] in_sample_y,
   output logic signed [jdsm_pkg::SPEED_W-1:0] out_speed_x,
   output logic signed [jdsm_pkg::SPEED_W-1:0] out_speed_y,
   output logic                            out_centre_ready
);
   import jdsm_pkg::*;

   localparam logic [CNT_W-1:0]       CALIB_LAST  = CNT_W'(CALIB_SAMPLES - 1);
   localparam logic [DEN_W-1:0]       CALIB_DEN   = DEN_W'(CALIB_SAMPLES);
   localparam logic [NUM_W-1:0]       SPEED_MAX_N = NUM_W'(SPEED_MAX);
   localparam logic [SPEED_W-1:0]     SPEED_POS   = SPEED_W'(SPEED_MAX);
   localparam logic [SPEED_W-1:0]     SPEED_NEG   = SPEED_W'(-SPEED_MAX);
   localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = CENTRE_RST[SAMPLE_BITS-1:0];
   localparam logic signed [DEV_W-1:0] FULL_S     = DEV_W'(FULL_SCALE);

   // captured input word
   logic                   op_ff;
   logic [SAMPLE_BITS-1:0] sx_ff, sy_ff;

   // calibration state
   logic [SUM_W-1:0]       sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SAMPLE_BITS-1:0] centre_x_ff, centre_x_in, centre_y_ff, centre_y_in;
   logic                   calibrated_ff, calibrated_in;
   logic                   commit_ff, commit_in;

   // axis flags and result word
   axis_flags_type         fx_ff, fy_ff, fx_in, fy_in;
   logic [SPEED_W-1:0]     speed_x_ff, speed_x_in, speed_y_ff, speed_y_in;
   logic                   ready_ff, ready_in;

   // divider lanes
   logic                   div_start;
   logic [NUM_W-1:0]       num_x, num_y, quo_x, quo_y;
   logic [DEN_W-1:0]       den_x, den_y;
   logic                   busy_x, busy_y;

   logic                   calib_last;
   logic [SUM_W-1:0]       sum_x_add, sum_y_add;
   logic [NUM_W-1:0]       cnum_x, cnum_y;
   logic [DEN_W-1:0]       cden_x, cden_y;

   // classify one axis and build its scaling numerator / divisor
   function automatic axis_flags_type axis_eval(
      input  logic [SAMPLE_BITS-1:0] s,
      input  logic [SAMPLE_BITS-1:0] c,
      input  logic [DZ_W-1:0]        dz,
      output logic [NUM_W-1:0]       num,
      output logic [DEN_W-1:0]       den
   );
      axis_flags_type     f;
      logic signed [DEV_W-1:0] s_e, c_e, dz_e, dev, mag, span, opnd;
      s_e   = $signed({2'b00, s});
      c_e   = $signed({2'b00, c});
      dz_e  = $signed({{(DEV_W-DZ_W){1'b0}}, dz});
      dev   = s_e - c_e;
      mag   = (dev < 0) ? -dev : dev;
      f.zero = (dev == 0) || (mag < dz_e);
      f.pos  = dev > 0;
      span   = f.pos ? (FULL_S - c_e - dz_e) : (c_e - dz_e);
      f.sat  = span <= 0;
      opnd   = f.pos ? (dev - dz_e) : s_e;
      num    = {{(NUM_W-SAMPLE_BITS){1'b0}}, opnd[SAMPLE_BITS-1:0]} * SPEED_MAX_N;
      den    = DEN_W'(span[SAMPLE_BITS-1:0]);
      return f;
   endfunction

   // clamp the quotient and place it on its side of zero
   function automatic logic [SPEED_W-1:0] axis_speed(
      input axis_flags_type   f,
      input logic [NUM_W-1:0] q
   );
      logic [NUM_W-1:0]   qc;
      logic [SPEED_W-1:0] mag;
      qc  = (q > SPEED_MAX_N) ? SPEED_MAX_N : q;
      mag = qc[SPEED_W-1:0];
      if (f.zero) begin
         return '0;
      end else if (f.sat) begin
         return f.pos ? SPEED_POS : SPEED_NEG;
      end else begin
         return f.pos ? mag : (mag - SPEED_POS);
      end
   endfunction

   assign calib_last = count_ff == CALIB_LAST;
   assign sum_x_add  = sum_x_ff + {{(SUM_W-SAMPLE_BITS){1'b0}}, sx_ff};
   assign sum_y_add  = sum_y_ff + {{(SUM_W-SAMPLE_BITS){1'b0}}, sy_ff};

   always_comb begin
      fx_in = axis_eval(sx_ff, centre_x_ff, dz_thresh, cnum_x, cden_x);
      fy_in = axis_eval(sy_ff, centre_y_ff, dz_thresh, cnum_y, cden_y);
      if (op_ff) begin
         num_x = cnum_x;
         num_y = cnum_y;
         den_x = cden_x;
         den_y = cden_y;
      end else begin
         num_x = NUM_W'(sum_x_add);
         num_y = NUM_W'(sum_y_add);
         den_x = CALIB_DEN;
         den_y = CALIB_DEN;
      end
   end

   assign div_start = cmd.eval && (op_ff || calib_last);

   always_comb begin
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      count_in      = count_ff;
      commit_in     = commit_ff;
      centre_x_in   = centre_x_ff;
      centre_y_in   = centre_y_ff;
      calibrated_in = calibrated_ff;
      speed_x_in    = speed_x_ff;
      speed_y_in    = speed_y_ff;
      ready_in      = ready_ff;
      if (cmd.eval) begin
         commit_in = !op_ff && calib_last;
         if (!op_ff) begin
            if (calib_last) begin
               sum_x_in = '0;
               sum_y_in = '0;
               count_in = '0;
            end else begin
               sum_x_in = sum_x_add;
               sum_y_in = sum_y_add;
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (cmd.finish) begin
         if (commit_ff) begin
            centre_x_in   = quo_x[SAMPLE_BITS-1:0];
            centre_y_in   = quo_y[SAMPLE_BITS-1:0];
            calibrated_in = 1'b1;
         end
         speed_x_in = op_ff ? axis_speed(fx_ff, quo_x) : '0;
         speed_y_in = op_ff ? axis_speed(fy_ff, quo_y) : '0;
         ready_in   = calibrated_ff || commit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         count_ff      <= '0;
         centre_x_ff   <= CENTRE_RESET;
         centre_y_ff   <= CENTRE_RESET;
         calibrated_ff <= 1'b0;
         commit_ff     <= 1'b0;
      end else begin
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         count_ff      <= count_in;
         centre_x_ff   <= centre_x_in;
         centre_y_ff   <= centre_y_in;
         calibrated_ff <= calibrated_in;
         commit_ff     <= commit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= in_op;
         sx_ff <= in_sample_x;
         sy_ff <= in_sample_y;
      end
      if (cmd.eval) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
      speed_x_ff <= speed_x_in;
      speed_y_ff <= speed_y_in;
      ready_ff   <= ready_in;
   end

   jdsm_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_x),
      .den      (den_x),
      .busy     (busy_x),
      .quotient (quo_x)
   );

   jdsm_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_y),
      .den      (den_y),
      .busy     (busy_y),
      .quotient (quo_y)
   );

   assign status.div_needed = op_ff || calib_last;
   assign status.div_busy   = busy_x || busy_y;
   assign status.calibrated = calibrated_ff;

   assign out_speed_x      = $signed(speed_x_ff);
   assign out_speed_y      = $signed(speed_y_ff);
   assign out_centre_ready = ready_ff;

endmodule

FILE: rtl/jdsm_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsm_controller: sequencing of one word at a time
// Capture, evaluate, wait on any divide, then hand over to the output register.
// ----------------------------------------------------------------------------
module jdsm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output jdsm_pkg::dp_cmd_type    cmd,
   input  jdsm_pkg::dp_status_type status
);
   import jdsm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_ready;
      cmd.capture = 1'b0;
      cmd.eval    = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.div_needed ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = valid_ff;

endmodule

FILE: rtl/joystick_deadzone_speed_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_speed_mapper_core: joystick dead-zone speed mapper
// Per-axis centre calibration and dead-zone linear mapping onto -100..100.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): one word carries op, sample_x, sample_y.
//    op = 0 is a rest sample for calibration, op = 1 a conversion sample.
//  - rsp channel (valid/ready): exactly one result word per request word:
//    speed_x, speed_y (signed) and centre_ready.
//  - APB-style register port: dead-zone threshold at byte address 0 (reset 20).
//    Write it only while no word is in flight.
//  - Steps: a calibration word that does not close a run is captured,
//    evaluated and then loaded as the result. A conversion word, or the
//    word that closes a calibration run, also runs both dividers over NUM_W
//    quotient bits (17 with the default sizing) before its result is loaded.
//  - Flow: one word at a time; req_ready rises again as the result is
//    loaded. The per-axis radix-2 dividers set the pace of words that divide.
//  - Reset clears sums and count, puts both centres at mid-scale (512) and
//    clears the calibrated flag; centre_ready itself is not reset.
//  - A stalled receiver holds the result in the output register; the next
//    word is accepted and worked on, then waits until the register frees up.
// ----------------------------------------------------------------------------
module joystick_deadzone_speed_mapper_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [jdsm_pkg::SAMPLE_BITS-1:0]  req_sample_x,
   input  logic [jdsm_pkg::SAMPLE_BITS-1:0]  req_sample_y,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [jdsm_pkg::SPEED_W-1:0] rsp_speed_x,
   output logic signed [jdsm_pkg::SPEED_W-1:0] rsp_speed_y,
   output logic                              rsp_centre_ready,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [jdsm_pkg::ADDR_W-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import jdsm_pkg::*;

   localparam logic [DZ_W-1:0] DZ_RESET_V = DZ_W'(DZ_RESET);

   dp_cmd_type    cmd;
   dp_status_type status;

   // threshold register; register index is the word address bit
   logic [DZ_W-1:0] dz_thresh_ff, dz_thresh_in;
   logic            csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      dz_thresh_in = dz_thresh_ff;
      if (csr_wr && (paddr[2] == REG_DZ_THRESH)) begin
         dz_thresh_in = pwdata[DZ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_thresh_ff <= DZ_RESET_V;
      end else begin
         dz_thresh_ff <= dz_thresh_in;
      end
   end

   // reads beyond the register list return zero
   assign prdata = (paddr[2] == REG_DZ_THRESH) ?
                   {{(32-DZ_W){1'b0}}, dz_thresh_ff} : 32'd0;

   jdsm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   jdsm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .dz_thresh        (dz_thresh_ff),
      .in_op            (req_op),
      .in_sample_x      (req_sample_x),
      .in_sample_y      (req_sample_y),
      .out_speed_x      (rsp_speed_x),
      .out_speed_y      (rsp_speed_y),
      .out_centre_ready (rsp_centre_ready)
   );

   // no new word is taken while the dividers are running
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.div_busy)
      else $error("request accepted while dividers busy");

   // one word in flight: acceptance closes the request side
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("back-to-back accept in sequential core");

   // calibration, once achieved, is never lost
   assert property (@(posedge clock) disable iff (reset)
      !$fell(status.calibrated))
      else $error("calibrated flag dropped");

   // speeds stay within the mapped range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_x <= 8'sd100) && (rsp_speed_x >= -8'sd100) &&
                    (rsp_speed_y <= 8'sd100) && (rsp_speed_y >= -8'sd100))
      else $error("speed out of range");

endmodule

FILE: tb/sv/joystick_deadzone_speed_mapper_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_speed_mapper_core_test: self-checking bench for the mapper
// Drives stick words through the req channel and predicts every rsp word
// with an independent calibration and dead-zone mapping model. The CSR port
// sets the dead zone between phases. Directed corner words come first, then
// random calibration runs and conversion bursts. Both channels idle at random.
// ----------------------------------------------------------------------------
module joystick_deadzone_speed_mapper_core_test;
   import jdsm_pkg::*;

   localparam logic OP_CALIB   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // byte addresses on the CSR port: the threshold is register 0
   localparam logic [ADDR_W-1:0] DZ_ADDR     = ADDR_W'({REG_DZ_THRESH, 2'b00});
   localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

   localparam int WORD_GOAL    = 900;
   localparam int DRAIN_CYCLES = 24;   // a little over the slowest word latency
   localparam int HOLD_AT      = 60;   // result count that starts the long stall
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic                   op;
      logic [SAMPLE_BITS-1:0] sx;
      logic [SAMPLE_BITS-1:0] sy;
   } stick_word_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] vx;
      logic signed [SPEED_W-1:0] vy;
      logic                      ready;
   } speed_word_type;

   // DUT connections; every input has a known value from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = OP_CALIB;
   logic [SAMPLE_BITS-1:0]    req_sample_x = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SPEED_W-1:0] rsp_speed_x;
   logic signed [SPEED_W-1:0] rsp_speed_y;
   logic                      rsp_centre_ready;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   stick_word_type stick_words[$];   // words waiting for the driver
   speed_word_type speed_queue[$];   // predicted results, oldest first
   int          words_made = 0;
   int          mismatches = 0;
   bit          req_burst  = 1'b0; // no gaps on the sender while set
   bit          rsp_burst  = 1'b0; // no random stalls on the receiver while set

   // mapper model state, updated on accepted words and CSR writes
   logic [DZ_W-1:0]        model_dz      = DZ_W'(DZ_RESET);
   int                     cal_sum_x     = 0;
   int                     cal_sum_y     = 0;
   int                     cal_count     = 0;
   logic [SAMPLE_BITS-1:0] ctr_x         = SAMPLE_BITS'(CENTRE_RST);
   logic [SAMPLE_BITS-1:0] ctr_y         = SAMPLE_BITS'(CENTRE_RST);
   logic                   is_calibrated = 1'b0;

   joystick_deadzone_speed_mapper_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speed_x      (rsp_speed_x),
      .rsp_speed_y      (rsp_speed_y),
      .rsp_centre_ready (rsp_centre_ready),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------
   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // One axis: offset from centre, dead zone, then a linear map of the
   // remaining span on that side onto 0..100 or -100..0.
   function automatic logic signed [SPEED_W-1:0] axis_speed(
      logic [SAMPLE_BITS-1:0] smp, logic [SAMPLE_BITS-1:0] ctr, logic [DZ_W-1:0] dz);
      int s, c, d, dev, mag, den, v;
      s   = smp;
      c   = ctr;
      d   = dz;
      dev = s - c;
      mag = (dev < 0) ? -dev : dev;
      if (dev == 0 || mag < d) begin
         v = 0;
      end else if (dev > 0) begin
         den = FULL_SCALE - c - d;
         // dead zone runs past the span: pin to full speed
         if (den <= 0) v = SPEED_MAX;
         else          v = clamp_int(((dev - d) * SPEED_MAX) / den, 0, SPEED_MAX);
      end else begin
         den = c - d;
         if (den <= 0) v = -SPEED_MAX;
         // dev + c is the sample itself
         else          v = clamp_int((s * SPEED_MAX) / den - SPEED_MAX, -SPEED_MAX, 0);
      end
      return v[SPEED_W-1:0];
   endfunction

   // Advance the model by one accepted word and give back its result word.
   function automatic speed_word_type predict_word(stick_word_type w);
      speed_word_type r;
      r.vx = '0;
      r.vy = '0;
      if (w.op == OP_CALIB) begin
         cal_sum_x += w.sx;
         cal_sum_y += w.sy;
         cal_count++;
         if (cal_count >= CALIB_SAMPLES) begin
            ctr_x         = SAMPLE_BITS'(cal_sum_x / CALIB_SAMPLES);
            ctr_y         = SAMPLE_BITS'(cal_sum_y / CALIB_SAMPLES);
            cal_sum_x     = 0;
            cal_sum_y     = 0;
            cal_count     = 0;
            is_calibrated = 1'b1;
         end
      end else begin
         // conversions leave any open calibration run untouched
         r.vx = axis_speed(w.sx, ctr_x, model_dz);
         r.vy = axis_speed(w.sy, ctr_y, model_dz);
      end
      r.ready = is_calibrated;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: CSR model, result check, then prediction of the word
   // accepted at this edge. One block keeps the queue order fixed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      speed_word_type want;
      stick_word_type took;
      if (!reset) begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               // other addresses hold no register
               if (paddr == DZ_ADDR) model_dz = pwdata[DZ_W-1:0];
            end else if (paddr == DZ_ADDR && prdata !== {{(32-DZ_W){1'b0}}, model_dz}) begin
               mismatches++;
               $display("%0t: dz_thresh read: expected %0d, got %0d",
                        $time, model_dz, prdata);
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (speed_queue.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none pending: x=%0d y=%0d ready=%0b",
                        $time, rsp_speed_x, rsp_speed_y, rsp_centre_ready);
            end else begin
               want = speed_queue.pop_front();
               if (rsp_speed_x !== want.vx) begin
                  mismatches++;
                  $display("%0t: speed_x: expected %0d, got %0d",
                           $time, $signed(want.vx), rsp_speed_x);
               end
               if (rsp_speed_y !== want.vy) begin
                  mismatches++;
                  $display("%0t: speed_y: expected %0d, got %0d",
                           $time, $signed(want.vy), rsp_speed_y);
               end
               if (rsp_centre_ready !== want.ready) begin
                  mismatches++;
                  $display("%0t: centre_ready: expected %0b, got %0b",
                           $time, want.ready, rsp_centre_ready);
               end
            end
         end

         if (req_valid && req_ready) begin
            took.op = req_op;
            took.sx = req_sample_x;
            took.sy = req_sample_y;
            speed_queue.push_back(predict_word(took));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: each word carries its own random gap of idle cycles after it.
   // A word stays on the bus unchanged until the DUT takes it.
   // ---------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin : req_driver
      stick_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (req_valid && !req_ready) begin
         // waiting for the DUT to take the word
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (stick_words.size() != 0) begin
         nxt = stick_words.pop_front();
         req_valid    <= 1'b1;
         req_op       <= nxt.op;
         req_sample_x <= nxt.sx;
         req_sample_y <= nxt.sy;
         req_gap      <= req_burst ? 0 : $urandom_range(0, 3);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall after each word; once, after HOLD_AT + 1 words,
   // it keeps rsp_ready low for a hold so the DUT backs up onto req_ready.
   // ---------------------------------------------------------------------
   int rsp_wait  = 0;
   int hold_left = 0;
   int rsp_taken = 0;

   always @(posedge clock) begin : rsp_driver
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         hold_left <= 0;
         rsp_taken <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_taken <= rsp_taken + 1;
         if (rsp_taken == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            w = rsp_burst ? 0 : $urandom_range(0, 3);
            rsp_wait  <= w;
            rsp_ready <= (w == 0);
         end
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
      return SAMPLE_BITS'(clamp_int(v, 0, FULL_SCALE));
   endfunction

   task automatic push_word(logic op, int sx, int sy);
      stick_word_type w;
      w.op = op;
      w.sx = clip_sample(sx);
      w.sy = clip_sample(sy);
      stick_words.push_back(w);
      words_made++;
   endtask

   // Conversion sample: uniform, rail, or near the dead-zone edge.
   function automatic int probe_sample(int c, int dz);
      int off;
      case ($urandom_range(0, 5))
         0, 1:    return $urandom_range(0, FULL_SCALE);
         2:       return $urandom_range(0, 1) ? FULL_SCALE : 0;
         default: begin
            off = dz + int'($urandom_range(0, 4)) - 2;
            return $urandom_range(0, 1) ? c + off : c - off;
         end
      endcase
   endfunction

   // Calibration words around one rest point, with a stray conversion now
   // and then in the middle of the run.
   task automatic push_calib_run(int count);
      int tx, ty, spread;
      case ($urandom_range(0, 5))
         0:       begin tx = 0;          ty = 0;          spread = 0; end
         1:       begin tx = FULL_SCALE; ty = FULL_SCALE; spread = 0; end
         2:       begin tx = 0;          ty = FULL_SCALE; spread = 0; end
         default: begin
            tx     = $urandom_range(0, FULL_SCALE);
            ty     = $urandom_range(0, FULL_SCALE);
            spread = $urandom_range(0, 8);
         end
      endcase
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            push_word(OP_CONVERT, $urandom_range(0, FULL_SCALE), $urandom_range(0, FULL_SCALE));
         push_word(OP_CALIB, tx + int'($urandom_range(0, 2 * spread)) - spread,
                   ty + int'($urandom_range(0, 2 * spread)) - spread);
      end
   endtask

   // Idle means: nothing queued, nothing on the bus, nothing outstanding.
   // Checked on the falling edge so all edge updates have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (stick_words.size() != 0 || req_valid || speed_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // the scoreboard checks prdata on the access edge
   task automatic csr_read(logic [ADDR_W-1:0] addr);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int  dz, n;
      bit  first_run;
      first_run = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset dead zone, reset centres, no calibration yet.
      push_word(OP_CONVERT, 512, 512);        // zero deviation
      push_word(OP_CONVERT, 531, 493);        // just inside the dead zone
      push_word(OP_CONVERT, 532, 492);        // on the dead-zone edge
      push_word(OP_CONVERT, FULL_SCALE, 0);
      push_word(OP_CONVERT, 0, FULL_SCALE);
      push_word(OP_CONVERT, 700, 300);
      push_word(OP_CONVERT, 'h2AA, 'h155);
      push_word(OP_CALIB, FULL_SCALE, 0);     // opens a calibration run
      push_word(OP_CONVERT, FULL_SCALE, FULL_SCALE); // conversion inside the run
      wait_idle();

      // Dead zone of zero: only an exact centre reads zero.
      csr_write(DZ_ADDR, 32'h0000_0000);
      csr_read(DZ_ADDR);
      push_word(OP_CONVERT, 512, 512);
      push_word(OP_CONVERT, 513, 511);
      push_word(OP_CONVERT, FULL_SCALE, 0);
      push_word(OP_CALIB, 0, FULL_SCALE);
      wait_idle();

      // Write beyond the register map must not touch the threshold.
      csr_write(UNUSED_ADDR, 32'h0000_01FF);
      csr_read(DZ_ADDR);

      // Widest dead zone: positive side has no span left and pins to +100.
      csr_write(DZ_ADDR, 32'hFFFF_FFFF);
      csr_read(DZ_ADDR);
      push_word(OP_CONVERT, FULL_SCALE, 0);
      push_word(OP_CONVERT, 0, FULL_SCALE);
      push_word(OP_CONVERT, 512, 512);
      push_word(OP_CONVERT, 1000, 10);

      // Random phases: a calibration run (full, partial or none), then a
      // dead-zone setting picked against the new centres, then conversions.
      while (words_made < WORD_GOAL) begin
         wait_idle();
         req_burst = ($urandom_range(0, 4) == 0);
         rsp_burst = ($urandom_range(0, 4) == 0);
         n = $urandom_range(0, 7);
         if (first_run || n < 5) push_calib_run(CALIB_SAMPLES - cal_count);
         else if (n < 7)         push_calib_run($urandom_range(1, 30));
         first_run = 1'b0;
         wait_idle();

         case ($urandom_range(0, 7))
            0:       dz = 0;
            1:       dz = 511;
            // span divisor exactly zero on one side of the x axis
            2:       dz = (ctr_x <= 511) ? ctr_x : FULL_SCALE - ctr_x;
            3:       dz = clamp_int(((ctr_y <= 511) ? ctr_y : FULL_SCALE - ctr_y)
                                    + int'($urandom_range(0, 2)) - 1, 0, 511);
            4:       dz = $urandom_range(0, 511);
            default: dz = $urandom_range(0, 120);
         endcase
         csr_write(DZ_ADDR, ($urandom & 32'hFFFF_FE00) | 32'(dz));
         if ($urandom_range(0, 3) == 0) csr_write(UNUSED_ADDR, $urandom);
         csr_read(DZ_ADDR);

         repeat ($urandom_range(30, 70))
            push_word(OP_CONVERT, probe_sample(ctr_x, dz), probe_sample(ctr_y, dz));
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, several times the slowest passing run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
